@@ hw/rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared codes and field widths of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // operation codes, the unused code acts as peek
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

@@ hw/rtl/mhpq_if.sv @@
// ----------------------------------------------------------------------------
// mhpq_req_if / mhpq_rsp_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface mhpq_req_if import mhpq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [OP_W-1:0]     operation;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic        [STATUS_W-1:0] status;
  logic signed [VALUE_W-1:0]  max_value;
  logic        [COUNT_W-1:0]  element_count;

  modport source (output valid, ok, status, max_value, element_count, input ready);
  modport sink   (input valid, ok, status, max_value, element_count, output ready);
endinterface

@@ hw/rtl/max_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap over signed values held in one two-read, one-write RAM.
// ----------------------------------------------------------------------------
// One operation beat is taken at a time and answered by one result beat.
// Peek reads the root; a refused operation is answered without a RAM access.
// Insert places the value in a new last slot and climbs past each smaller
// parent; delete-max reads the root and the last element and sinks the moved
// element past each larger child, with no write when it removes the only
// element. Each level is one compare of the registered RAM read data, done in
// the cycle that writes the moved entry and reads the next parent or both next
// children. The result sits in an output register, and a stalled result beat
// holds the next operation only once it finishes.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mhpq_req_if.sink           req_i,
  mhpq_rsp_if.source         rsp_o
);

  localparam int unsigned CW        = $clog2(CAPACITY + 1);
  localparam int unsigned AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned MEM_DEPTH = 1 << AW;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_CMP, S_DEL_LOAD, S_DEL_CMP, S_PUT, S_PEEK, S_DONE
  } state_e;

  function automatic logic [AW-1:0] addr_of(logic [CW+1:0] n);
    logic [CW+1:0] m;
    m = n - (CW+2)'(1);
    return m[AW-1:0];
  endfunction

  state_e                        state_q, state_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic signed [DATA_WIDTH-1:0]  elem_q, elem_d;
  logic                          res_ok_q, res_ok_d;
  logic [STATUS_W-1:0]           res_status_q, res_status_d;
  logic signed [DATA_WIDTH-1:0]  res_max_q, res_max_d;

  logic                          rsp_valid_q;
  logic                          rsp_ok_q;
  logic [STATUS_W-1:0]           rsp_status_q;
  logic signed [VALUE_W-1:0]     rsp_max_q;
  logic [COUNT_W-1:0]            rsp_count_q;
  logic                          rsp_load;

  logic signed [DATA_WIDTH-1:0]  mem [MEM_DEPTH];
  logic                          mem_we, re_a, re_b;
  logic [AW-1:0]                 waddr, raddr_a, raddr_b;
  logic signed [DATA_WIDTH-1:0]  wdata;
  logic signed [DATA_WIDTH-1:0]  rd_a_q, rd_b_q;

  logic                          req_fire;
  logic [CW-1:0]                 cnt_inc;
  logic [CW-1:0]                 parent;
  logic [CW+1:0]                 lchild, child, cnt_x, half_x;
  logic                          pick_right;
  logic signed [DATA_WIDTH-1:0]  child_val;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  assign cnt_inc    = cnt_q + CW'(1);
  assign parent     = idx_q >> 1;
  assign cnt_x      = (CW+2)'(cnt_q);
  assign half_x     = (CW+2)'(cnt_q >> 1);
  assign lchild     = {1'b0, idx_q, 1'b0};
  assign pick_right = (lchild < cnt_x) && (rd_b_q > rd_a_q);
  assign child      = pick_right ? lchild + (CW+2)'(1) : lchild;
  assign child_val  = pick_right ? rd_b_q : rd_a_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    elem_d       = elem_q;
    res_ok_d     = res_ok_q;
    res_status_d = res_status_q;
    res_max_d    = res_max_q;
    mem_we       = 1'b0;
    waddr        = addr_of((CW+2)'(idx_q));
    wdata        = elem_q;
    re_a         = 1'b0;
    re_b         = 1'b0;
    raddr_a      = '0;
    raddr_b      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_ok_d     = 1'b1;
          res_status_d = STATUS_OK;
          res_max_d    = '0;
          if (req_i.operation == OP_INSERT) begin
            if (cnt_q >= CW'(CAPACITY)) begin
              res_ok_d     = 1'b0;
              res_status_d = STATUS_FULL;
              state_d      = S_DONE;
            end else begin
              cnt_d  = cnt_inc;
              idx_d  = cnt_inc;
              elem_d = DATA_WIDTH'(req_i.value);
              if (cnt_q == '0) begin
                state_d = S_PUT;
              end else begin
                re_a    = 1'b1;
                raddr_a = addr_of((CW+2)'(cnt_inc >> 1));
                state_d = S_INS_CMP;
              end
            end
          end else if (cnt_q == '0) begin
            res_ok_d     = 1'b0;
            res_status_d = STATUS_EMPTY;
            state_d      = S_DONE;
          end else if (req_i.operation == OP_DELETE) begin
            re_a    = 1'b1;
            raddr_a = '0;
            re_b    = 1'b1;
            raddr_b = addr_of(cnt_x);
            cnt_d   = cnt_q - CW'(1);
            state_d = S_DEL_LOAD;
          end else begin
            re_a    = 1'b1;
            raddr_a = '0;
            state_d = S_PEEK;
          end
        end
      end
      S_INS_CMP: begin
        if (elem_q > rd_a_q) begin
          mem_we = 1'b1;
          wdata  = rd_a_q;
          idx_d  = parent;
          if (parent > CW'(1)) begin
            re_a    = 1'b1;
            raddr_a = addr_of((CW+2)'(parent >> 1));
          end else begin
            state_d = S_PUT;
          end
        end else begin
          mem_we  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DEL_LOAD: begin
        res_max_d = rd_a_q;
        elem_d    = rd_b_q;
        idx_d     = CW'(1);
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else if (cnt_q >= CW'(2)) begin
          re_a    = 1'b1;
          raddr_a = addr_of((CW+2)'(2));
          re_b    = 1'b1;
          raddr_b = addr_of((CW+2)'(3));
          state_d = S_DEL_CMP;
        end else begin
          state_d = S_PUT;
        end
      end
      S_DEL_CMP: begin
        mem_we = 1'b1;
        if (elem_q >= child_val) begin
          state_d = S_DONE;
        end else begin
          wdata = child_val;
          idx_d = child[CW-1:0];
          if (child <= half_x) begin
            re_a    = 1'b1;
            raddr_a = addr_of({child[CW:0], 1'b0});
            re_b    = 1'b1;
            raddr_b = addr_of({child[CW:0], 1'b0} + (CW+2)'(1));
          end else begin
            state_d = S_PUT;
          end
        end
      end
      S_PUT: begin
        mem_we  = 1'b1;
        state_d = S_DONE;
      end
      S_PEEK: begin
        res_max_d = rd_a_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_q <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b_q <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    elem_q       <= elem_d;
    res_ok_q     <= res_ok_d;
    res_status_q <= res_status_d;
    res_max_q    <= res_max_d;
    if (rsp_load) begin
      rsp_ok_q     <= res_ok_q;
      rsp_status_q <= res_status_q;
      rsp_max_q    <= VALUE_W'(res_max_q);
      rsp_count_q  <= COUNT_W'(cnt_q);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.ok            = rsp_ok_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.max_value     = rsp_max_q;
  assign rsp_o.element_count = rsp_count_q;

endmodule

@@ dv/max_heap_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Drives insert, delete-max and peek beats into the heap queue and compares
// every result beat against a behavioral max-heap kept alongside the run.
// Directed beats cover the empty and full refusals, the unused operation code
// and the value extremes. Random traffic then swings the heap between empty
// and full under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int unsigned HEAP_DEPTH     = 16;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned PHASE_ITEMS    = 185;

  // the unused code behaves as peek
  localparam logic [OP_W-1:0] OP_PEEK_ALIAS = 2'd3;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic                       ok;
    logic        [STATUS_W-1:0] status;
    logic signed [VALUE_W-1:0]  max_value;
    logic        [COUNT_W-1:0]  element_count;
  } heap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mhpq_req_if req_bus ();
  mhpq_rsp_if rsp_bus ();

  max_heap_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  logic signed [VALUE_W-1:0] heap_model [1:HEAP_DEPTH];
  int unsigned               heap_fill;
  heap_result_t              pending_results [$];

  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  bit          filling;

  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned full_refusals;
  int unsigned empty_refusals;
  int unsigned max_removals;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic heap_result_t heap_apply_op(input logic [OP_W-1:0] op,
                                                 input logic signed [VALUE_W-1:0] val);
    heap_result_t              res;
    int unsigned               idx;
    int unsigned               child;
    logic signed [VALUE_W-1:0] moved;
    res.ok        = 1'b1;
    res.status    = STATUS_OK;
    res.max_value = '0;
    if (op == OP_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        res.ok     = 1'b0;
        res.status = STATUS_FULL;
      end else begin
        heap_fill++;
        idx = heap_fill;
        while (idx > 1 && val > heap_model[idx/2]) begin
          heap_model[idx] = heap_model[idx/2];
          idx = idx / 2;
        end
        heap_model[idx] = val;
      end
    end else if (heap_fill == 0) begin
      res.ok     = 1'b0;
      res.status = STATUS_EMPTY;
    end else begin
      res.max_value = heap_model[1];
      if (op == OP_DELETE) begin
        moved = heap_model[heap_fill];
        heap_fill--;
        idx = 1;
        if (heap_fill > 0) begin
          while (idx <= heap_fill / 2) begin
            child = idx * 2;
            if (child < heap_fill && heap_model[child+1] > heap_model[child]) child++;
            if (moved >= heap_model[child]) break;
            heap_model[idx] = heap_model[child];
            idx = child;
          end
          heap_model[idx] = moved;
        end
      end
    end
    res.element_count = heap_fill[COUNT_W-1:0];
    return res;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2, 3, 4: return int'($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val);
    heap_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.operation <= op;
    req_bus.value     <= val;
    do @(posedge clk_i); while (!req_bus.ready);
    want = heap_apply_op(op, val);
    pending_results.push_back(want);
    items_sent++;
    if (want.status == STATUS_FULL) full_refusals++;
    if (want.status == STATUS_EMPTY) empty_refusals++;
    if (op == OP_DELETE && want.ok) max_removals++;
  endtask

  task automatic test_empty_refusals();
    send_op(OP_DELETE, pick_value());
    send_op(OP_PEEK, pick_value());
    send_op(OP_PEEK_ALIAS, pick_value());
  endtask

  task automatic test_fill_extremes();
    logic signed [VALUE_W-1:0] seeds [10];
    seeds = '{VALUE_MAX, VALUE_MIN, 0, -1, 1, VALUE_MIN + 1, VALUE_MAX - 1, 5, 5, 5};
    foreach (seeds[i]) send_op(OP_INSERT, seeds[i]);
    while (heap_fill < HEAP_DEPTH) send_op(OP_INSERT, pick_value());
  endtask

  task automatic test_full_refusal();
    send_op(OP_INSERT, pick_value());
    send_op(OP_PEEK, pick_value());
    send_op(OP_PEEK_ALIAS, pick_value());
    repeat (3) send_op(OP_DELETE, pick_value());
  endtask

  // traffic that swings the heap between empty and full
  task automatic test_random_mix(input int unsigned count, input int unsigned send_pct,
                                 input int unsigned stall_pct);
    int unsigned      roll;
    logic [OP_W-1:0]  op;
    send_idle_pct = send_pct;
    rsp_stall_pct = stall_pct;
    repeat (count) begin
      if (heap_fill == HEAP_DEPTH && $urandom_range(1)) filling = 1'b0;
      if (heap_fill == 0 && $urandom_range(1)) filling = 1'b1;
      roll = $urandom_range(99);
      if (roll < (filling ? 70 : 25)) op = OP_INSERT;
      else if (roll < (filling ? 88 : 85)) op = OP_DELETE;
      else if (roll < 95) op = OP_PEEK;
      else op = OP_PEEK_ALIAS;
      send_op(op, pick_value());
    end
  endtask

  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.ok !== want.ok) report_mismatch("ok", rsp_bus.ok, want.ok);
        if (rsp_bus.status !== want.status)
          report_mismatch("status", rsp_bus.status, want.status);
        if (rsp_bus.max_value !== want.max_value)
          report_mismatch("max_value", rsp_bus.max_value, want.max_value);
        if (rsp_bus.element_count !== want.element_count)
          report_mismatch("element_count", rsp_bus.element_count, want.element_count);
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("max_heap_priority_queue_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.operation = OP_INSERT;
    req_bus.value     = '0;
    heap_fill         = 0;
    send_idle_pct     = 0;
    rsp_stall_pct     = 0;
    filling           = 1'b1;
    items_sent        = 0;
    full_refusals     = 0;
    empty_refusals    = 0;
    max_removals      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_refusals();
    test_fill_extremes();
    test_full_refusal();
    test_random_mix(PHASE_ITEMS, 0, 0);
    test_random_mix(PHASE_ITEMS, 69, 0);
    test_random_mix(PHASE_ITEMS, 0, 69);
    test_random_mix(PHASE_ITEMS, 22, 22);

    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d operation beats, %0d max removals, %0d full and %0d empty refusals",
             items_sent, max_removals, full_refusals, empty_refusals);
    $display("compared %0d result beats, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("max_heap_priority_queue_tb OK");
    end else begin
      $display("max_heap_priority_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ max_heap_priority_queue.f @@
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_if.sv
hw/rtl/max_heap_priority_queue.sv
dv/max_heap_priority_queue_tb.sv
